// ----- hw/rtl/typea_anticollision_step_core_assert.svh -----
// Assertion macros shared by the anticollision RTL.
// Needs nothing else; simulation-only bodies, empty when SYNTHESIS is set.
`ifndef TYPEA_ANTICOLLISION_STEP_CORE_ASSERT_SVH
`define TYPEA_ANTICOLLISION_STEP_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("anticollision assertion failed");
// next-cycle implication
`define TAC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("anticollision assertion failed");
`else
`define TAC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TAC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/tac_pkg.sv -----
// Types and constants for the type A anticollision step.
// No dependencies; used by tac_step and the top level.
package tac_pkg;

    typedef enum logic [1:0] {
        ST_NEXT = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } t_status;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_REPLY = 1'b1;

    localparam logic [7:0] NVB_FIRST   = 8'h20;
    localparam logic [7:0] NVB_FULL    = 8'h58;
    localparam logic [2:0] LEN_FIRST   = 3'd2;
    localparam logic [7:0] SEL_CL1     = 8'h93;
    localparam logic [2:0] UID_BYTES   = 3'd5;
    localparam logic [3:0] LEN_TOTAL   = 4'd6;
    localparam logic [2:0] KNOWN_MAX   = 3'd4;

    typedef struct packed {
        logic        action;
        logic        timed_out;
        logic        collided;
        logic [4:0]  coll_pos;
        logic [39:0] rx_data;
        logic [5:0]  rx_bits;
    } t_step_in;

    typedef struct packed {
        t_status     status;
        logic [7:0]  cmd_nvb;
        logic [7:0]  cmd_framing;
        logic [2:0]  cmd_length;
        logic [31:0] cmd_uid;
        logic [39:0] uid_out;
    } t_result;

    typedef struct packed {
        logic [2:0]  known_bytes;
        logic [39:0] uid_acc;
        logic [39:0] partial_uid;
    } t_ctx;

endpackage

// ----- hw/rtl/tac_step.sv -----
// Combinational anticollision step: one word plus kept context in,
// one result and the next context out. Uses tac_pkg.
module tac_step
    import tac_pkg::*;
(
    input  t_step_in i_word,
    input  t_ctx     i_ctx,
    output t_result  o_res,
    output t_ctx     o_ctx
);

    logic [4:0]  pos_m1;
    logic [3:0]  k;
    logic [2:0]  col;
    logic [7:0]  mask;
    logic [2:0]  rlen;
    logic [2:0]  kb_m1;
    logic [39:0] rx_sh;
    logic [3:0]  len_sum;
    logic        len_ok;
    logic [39:0] uid_n;
    logic [39:0] part_n;
    logic [7:0]  rx_byte;
    logic [7:0]  chk;

    always_comb begin
        pos_m1  = i_word.coll_pos - 5'd1;
        k       = {1'b0, pos_m1[2:0]} + 4'd1;
        col     = (i_word.coll_pos == 5'd0) ? 3'd4 : ({1'b0, pos_m1[4:3]} + 3'd1);
        mask    = (i_word.coll_pos[2:0] == 3'd0) ? 8'hFF
                                                 : 8'((9'd1 << i_word.coll_pos[2:0]) - 9'd1);
        // short reply counts as one byte
        rlen    = (i_word.rx_bits > 6'd8) ? i_word.rx_bits[5:3] : 3'd1;
        kb_m1   = i_ctx.known_bytes - 3'd1;
        rx_sh   = i_word.rx_data << {kb_m1, 3'b000};
        len_sum = {1'b0, rlen} + {1'b0, i_ctx.known_bytes};
        len_ok  = (i_ctx.known_bytes <= UID_BYTES) && (len_sum == LEN_TOTAL);
        uid_n   = i_ctx.uid_acc;
        part_n  = i_ctx.partial_uid;
        rx_byte = '0;
        chk     = '0;

        o_ctx = i_ctx;
        o_res = '{status: ST_ERR, cmd_nvb: '0, cmd_framing: '0, cmd_length: '0,
                  cmd_uid: '0, uid_out: i_ctx.uid_acc};

        if (i_word.action == ACT_START) begin
            o_ctx = '0;
            o_res = '{status: ST_NEXT, cmd_nvb: NVB_FIRST, cmd_framing: '0,
                      cmd_length: LEN_FIRST, cmd_uid: '0, uid_out: '0};
        end else if (i_word.timed_out) begin
            o_res.status = ST_ERR;
        end else if (i_word.collided) begin
            // bytes below the collision come from the reply, last one masked
            for (int b = 0; b < 5; b++) begin
                rx_byte = i_word.rx_data[8*b +: 8];
                if (3'(b) + 3'd1 < col) begin
                    part_n[8*b +: 8] = rx_byte;
                end else if (3'(b) + 3'd1 == col) begin
                    part_n[8*b +: 8] = rx_byte & mask;
                end
                if (3'(b) < col) begin
                    uid_n[8*b +: 8] = uid_n[8*b +: 8] | part_n[8*b +: 8];
                end
            end
            o_ctx.known_bytes  = col;
            o_ctx.uid_acc      = uid_n;
            o_ctx.partial_uid  = part_n;
            o_res.status       = ST_NEXT;
            o_res.cmd_nvb      = (i_word.coll_pos == 5'd0) ? NVB_FULL
                                 : (NVB_FIRST + {2'b00, pos_m1[4:3], k});
            o_res.cmd_framing  = (i_word.coll_pos == 5'd0) ? 8'h00 : {k, k};
            o_res.cmd_length   = col + LEN_FIRST;
            o_res.uid_out      = uid_n;
            for (int b = 0; b < 4; b++) begin
                o_res.cmd_uid[8*b +: 8] = (3'(b) < col) ? uid_n[8*b +: 8] : 8'h00;
            end
        end else begin
            if (i_ctx.known_bytes == 3'd0) begin
                len_ok = (rlen == UID_BYTES);
                uid_n  = i_word.rx_data;
            end else begin
                // tail of the UID from the known byte onward
                for (int b = 0; b < 5; b++) begin
                    if (3'(b) >= kb_m1) begin
                        part_n[8*b +: 8] = rx_sh[8*b +: 8];
                        uid_n[8*b +: 8]  = uid_n[8*b +: 8] | rx_sh[8*b +: 8];
                    end
                end
            end
            if (len_ok) begin
                chk = uid_n[7:0] ^ uid_n[15:8] ^ uid_n[23:16] ^ uid_n[31:24];
                o_ctx.uid_acc     = uid_n;
                o_ctx.partial_uid = part_n;
                o_res.status      = (uid_n[39:32] == chk) ? ST_DONE : ST_ERR;
                o_res.uid_out     = uid_n;
            end
        end
    end

endmodule

// ----- hw/rtl/typea_anticollision_step_core.sv -----
// Top level of the type A bit-oriented anticollision step.
// Depends on tac_pkg, tac_step and typea_anticollision_step_core_assert.svh.

// Reader-side anticollision for one cascade level. A word with tuser 0
// starts a run and returns the first command (count byte 0x20, length 2);
// a word with tuser 1 is a card reply and returns either the next command
// (status 0), UID complete with good check byte (status 1) or error
// (status 2). Exactly one result word leaves per input word, in order.
// Flow: a word is held in the input register, then the step logic writes
// the result register and the kept UID context on the same edge, so the
// next word already sees the updated context; throughput is one word per
// clock while the result register is free or draining, and m_axis_tvalid
// rises when the word moves from the input register to the result register.
// The stage register and the result register let a new word enter while
// a result waits for m_axis_tready. The select code register is write-only
// state for the command sender and does not alter any result.
`include "typea_anticollision_step_core_assert.svh"

module typea_anticollision_step_core
    import tac_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config write channel: select code byte
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_data,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: timed_out[0], collided[1], coll_pos[6:2], rx_data[46:7],
    //        rx_bits[52:47], zero pad [55:53]
    input  logic [55:0]  s_axis_tdata,
    // tuser: action[0]
    input  logic         s_axis_tuser,
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: cmd_nvb[7:0], cmd_framing[15:8], cmd_length[18:16],
    //        cmd_uid[50:19], uid_out[90:51], zero pad [95:91]
    output logic [95:0]  m_axis_tdata,
    // tuser: status[1:0]
    output logic [1:0]   m_axis_tuser
);

    logic      r_in_vld;
    t_step_in  r_in;
    logic      r_out_vld;
    t_result   r_out;
    t_ctx      r_ctx;
    logic [7:0] r_select_code;

    t_result   n_out;
    t_ctx      n_ctx;
    logic      advance;

    // stage moves when the result slot is free or draining
    assign advance       = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || advance;
    assign o_cfg_ready   = 1'b1;

    tac_step u_step (
        .i_word (r_in),
        .i_ctx  (r_ctx),
        .o_res  (n_out),
        .o_ctx  (n_ctx)
    );

    // control and context
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
            r_ctx         <= '0;
            r_select_code <= SEL_CL1;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_ctx     <= n_ctx;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_select_code <= i_cfg_data;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.action    <= s_axis_tuser;
            r_in.timed_out <= s_axis_tdata[0];
            r_in.collided  <= s_axis_tdata[1];
            r_in.coll_pos  <= s_axis_tdata[6:2];
            r_in.rx_data   <= s_axis_tdata[46:7];
            r_in.rx_bits   <= s_axis_tdata[52:47];
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {5'b0, r_out.uid_out, r_out.cmd_uid, r_out.cmd_length,
                            r_out.cmd_framing, r_out.cmd_nvb};

    // known byte count never runs past the four UID bytes
    `TAC_ASSERT_IMP(a_known_range, i_clk, i_rst_n, 1'b1, r_ctx.known_bytes <= KNOWN_MAX)
    // a start word clears the UID it reports and the kept UID
    `TAC_ASSERT_NXT(a_start_clears, i_clk, i_rst_n, advance && (r_in.action == ACT_START),
        (r_out.uid_out == 40'd0) && (r_ctx.uid_acc == 40'd0) && r_out_vld)
    // done and error results carry no command
    `TAC_ASSERT_IMP(a_final_no_cmd, i_clk, i_rst_n, r_out_vld && (r_out.status != ST_NEXT),
        (r_out.cmd_length == 3'd0) && (r_out.cmd_nvb == 8'd0))
    // a timeout leaves the kept context alone
    `TAC_ASSERT_NXT(a_timeout_hold, i_clk, i_rst_n,
        advance && (r_in.action == ACT_REPLY) && r_in.timed_out, $stable(r_ctx))
    // select code changes only on a config write
    `TAC_ASSERT_NXT(a_sel_hold, i_clk, i_rst_n, !(i_cfg_valid && o_cfg_ready),
        $stable(r_select_code))

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for typea_anticollision_step_core.
// Depends on tac_pkg and the RTL under hw/rtl; it drives both streams and
// the config channel and checks each result word against a local model.
module tb_top;
    import tac_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
    localparam int LONG_HOLD      = 80;    // receiver back-pressure stretch
    localparam int SETTLE_CYCLES  = 4;     // settling margin after the last result

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [7:0]   i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // tdata: timed_out, collided, coll_pos, rx_data, rx_bits, zero pad
    logic [55:0]  s_axis_tdata = '0;
    // tuser: action
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // tdata: cmd_nvb, cmd_framing, cmd_length, cmd_uid, uid_out, zero pad
    logic [95:0]  m_axis_tdata;
    // tuser: status
    logic [1:0]   m_axis_tuser;

    typea_anticollision_step_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Local copy of the anticollision context. Only the known byte count,
    // the merged UID and the partial UID feed any result field.
    // ------------------------------------------------------------------
    logic [2:0]  ctx_known = '0;
    logic [39:0] ctx_uid = '0;
    logic [39:0] ctx_partial = '0;

    t_step_in pending_words[$];   // words waiting for the driver
    t_result  results_due[$];     // expected result words, oldest first
    t_step_in offered_word;       // word currently on s_axis

    int n_queued = 0;
    int n_fail = 0;
    int n_results = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    logic hold_go = 1'b0;
    logic hold_done = 1'b0;
    int hold_left = 0;
    int stall_cycles = 0;

    // Mask of the low n bytes of a 40-bit UID.
    function automatic logic [39:0] low_bytes(input int n);
        if (n >= 5)
            return '1;
        return (40'd1 << (8 * n)) - 40'd1;
    endfunction

    // Four UID bytes plus their XOR check byte on top.
    function automatic logic [39:0] with_bcc(input logic [31:0] b);
        return {b[31:24] ^ b[23:16] ^ b[15:8] ^ b[7:0], b};
    endfunction

    function automatic logic [39:0] rand40();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[39:0];
    endfunction

    // Works out the result of one accepted word and advances the context.
    function automatic t_result anticoll_predict(input t_step_in w);
        t_result     r;
        int          p, col, rem, rlen, sh;
        logic [7:0]  nvb, msk, x;
        logic [39:0] sel;
        r = '0;
        r.status = ST_ERR;
        if (w.action == ACT_START) begin
            ctx_uid = '0;
            ctx_partial = '0;
            ctx_known = '0;
            r.status = ST_NEXT;
            r.cmd_nvb = NVB_FIRST;
            r.cmd_length = LEN_FIRST;
        end else if (w.timed_out) begin
            r.status = ST_ERR;  // context untouched
        end else if (w.collided) begin
            // position 0 stands for 32; the count byte is (bytes+1) in the
            // high nibble plus the bit count 1..8 in the last byte
            p = (w.coll_pos == 0) ? 32 : int'(w.coll_pos);
            col = (p - 1) / 8 + 1;
            rem = p - 8 * (col - 1);
            nvb = 8'(((col + 1) << 4) + rem);
            msk = (rem == 8) ? 8'hFF : 8'((1 << rem) - 1);
            sel = low_bytes(col);
            ctx_partial = (ctx_partial & ~sel) | (w.rx_data & sel);
            ctx_partial &= ~({32'd0, ~msk} << (8 * (col - 1)));
            ctx_uid |= ctx_partial & sel;
            ctx_known = 3'(col);
            r.status = ST_NEXT;
            r.cmd_nvb = nvb;
            r.cmd_framing = (w.coll_pos == 0) ? 8'h00 : {4'(rem), 4'(rem)};
            r.cmd_length = 3'(col + 2);
            r.cmd_uid = ctx_uid[31:0] & sel[31:0];
        end else begin
            rlen = (w.rx_bits > 6'd8) ? int'(w.rx_bits) / 8 : 1;
            col = int'(ctx_known);
            if (col == 0) begin
                if (rlen == 5) begin
                    ctx_uid = w.rx_data;
                    r.status = ST_DONE;
                end
            end else if (rlen + col == 6) begin
                sh = 8 * (col - 1);
                sel = low_bytes(rlen) << sh;
                ctx_partial = (ctx_partial & ~sel) | ((w.rx_data << sh) & sel);
                ctx_uid |= ctx_partial & sel;
                r.status = ST_DONE;
            end
            // a merged reply still has to pass the check byte
            if (r.status == ST_DONE) begin
                x = ctx_uid[7:0] ^ ctx_uid[15:8] ^ ctx_uid[23:16] ^ ctx_uid[31:24];
                if (ctx_uid[39:32] != x)
                    r.status = ST_ERR;
            end
        end
        r.uid_out = ctx_uid;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH word %0d %s: got %0h want %0h", n_results, field, got, want);
        n_fail++;
    endtask

    task automatic queue_item(input logic act, input logic tmo, input logic coll,
                              input logic [4:0] pos, input logic [39:0] rx,
                              input logic [5:0] bits);
        t_step_in w;
        w.action = act;
        w.timed_out = tmo;
        w.collided = coll;
        w.coll_pos = pos;
        w.rx_data = rx;
        w.rx_bits = bits;
        pending_words.push_back(w);
        n_queued++;
    endtask

    // One well-formed run: start, a few collision replies (maybe a timeout
    // in between), then the closing reply sized for the known byte count.
    task automatic queue_round();
        logic [39:0] uid, rx;
        int          col, pos, rlen, sh, n_coll;
        logic [5:0]  bits;
        uid = with_bcc($urandom());
        if ($urandom_range(9) == 0)
            uid[39:32] = 8'($urandom());
        queue_item(ACT_START, 1'($urandom()), 1'($urandom()), 5'($urandom()),
                   rand40(), 6'($urandom()));
        col = 0;
        n_coll = $urandom_range(0, 4);
        repeat (n_coll) begin
            if ($urandom_range(7) == 0)
                queue_item(ACT_REPLY, 1'b1, 1'($urandom()), 5'($urandom()),
                           rand40(), 6'($urandom()));
            pos = $urandom_range(0, 31);
            queue_item(ACT_REPLY, 1'b0, 1'b1, 5'(pos), uid, 6'($urandom()));
            col = (pos == 0) ? 4 : (pos - 1) / 8 + 1;
        end
        sh = (col == 0) ? 0 : 8 * (col - 1);
        rlen = (col == 0) ? 5 : 6 - col;
        // bytes past the reply length are junk the block must not merge
        rx = (uid >> sh) | (rand40() << (8 * rlen));
        bits = 6'(8 * rlen + $urandom_range(0, 7));
        if ($urandom_range(9) == 0)
            bits = 6'($urandom());
        queue_item(ACT_REPLY, 1'b0, 1'b0, 5'($urandom()), rx, bits);
    endtask

    task automatic queue_noise();
        queue_item(($urandom_range(9) == 0) ? ACT_START : ACT_REPLY,
                   1'($urandom()), 1'($urandom()), 5'($urandom()),
                   rand40(), 6'($urandom()));
    endtask

    // Sender pause: wait until every word went in and every result came out.
    task automatic drain();
        do @(posedge i_clk);
        while (pending_words.size() != 0 || n_results != n_queued);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_select(input logic [7:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued words; the expectation is computed at the
    // edge where the word is taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                results_due.push_back(anticoll_predict(offered_word));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    offered_word = pending_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= offered_word.action;
                    s_axis_tdata <= {3'b000, offered_word.rx_bits, offered_word.rx_data,
                                     offered_word.coll_pos, offered_word.collided,
                                     offered_word.timed_out};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: random stalls, plus one long hold-off so the block
    // fills up and pushes back on its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Monitor: every result word is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (results_due.size() == 0) begin
                report_mismatch("unexpected word", 64'(m_axis_tdata[90:51]), 64'd0);
            end else begin
                want = results_due.pop_front();
                if (m_axis_tuser != want.status)
                    report_mismatch("code", 64'(m_axis_tuser), 64'(want.status));
                if (m_axis_tdata[7:0] != want.cmd_nvb)
                    report_mismatch("nvb", 64'(m_axis_tdata[7:0]), 64'(want.cmd_nvb));
                if (m_axis_tdata[15:8] != want.cmd_framing)
                    report_mismatch("framing", 64'(m_axis_tdata[15:8]),
                                    64'(want.cmd_framing));
                if (m_axis_tdata[18:16] != want.cmd_length)
                    report_mismatch("length", 64'(m_axis_tdata[18:16]),
                                    64'(want.cmd_length));
                if (m_axis_tdata[50:19] != want.cmd_uid)
                    report_mismatch("cmd_uid", 64'(m_axis_tdata[50:19]), 64'(want.cmd_uid));
                if (m_axis_tdata[90:51] != want.uid_out)
                    report_mismatch("uid_out", 64'(m_axis_tdata[90:51]), 64'(want.uid_out));
            end
            n_results <= n_results + 1;
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                     || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        logic [39:0] uid;
        int          phase, goal;
        int          idle_tab[4];
        int          stall_tab[4];
        logic [7:0]  sel_tab[4];
        idle_tab  = '{0, 58, 0, 31};
        stall_tab = '{0, 0, 58, 31};
        sel_tab   = '{8'h00, 8'h95, 8'h97, 8'($urandom())};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_select(8'hFF);

        // directed: start with every ignored field set, timeout, full
        // replies with good and bad check byte, reply after done and after
        // error, wrong lengths (rx_bits 0, 8, 39, 63)
        queue_item(ACT_START, 1'b1, 1'b1, 5'h1F, '1, 6'h3F);
        queue_item(ACT_REPLY, 1'b1, 1'b0, 5'd0, '0, 6'd40);
        queue_item(ACT_REPLY, 1'b0, 1'b0, 5'd0, with_bcc(32'h44332211), 6'd40);
        queue_item(ACT_REPLY, 1'b0, 1'b0, 5'd0,
                   with_bcc(32'h44332211) ^ 40'h01_0000_0000, 6'd40);
        queue_item(ACT_REPLY, 1'b0, 1'b0, 5'd0, with_bcc(32'hDEADBEEF), 6'd47);
        queue_item(ACT_REPLY, 1'b0, 1'b0, 5'd0, '1, 6'd39);
        queue_item(ACT_REPLY, 1'b0, 1'b0, 5'd0, '1, 6'd0);
        queue_item(ACT_REPLY, 1'b0, 1'b0, 5'd0, '1, 6'd8);
        queue_item(ACT_REPLY, 1'b0, 1'b0, 5'd0, '1, 6'd63);
        // collision at position 32 (coded 0): full four bytes known
        uid = with_bcc(32'h807F01FE);
        queue_item(ACT_START, 1'b0, 1'b0, 5'd0, '0, 6'd0);
        queue_item(ACT_REPLY, 1'b0, 1'b1, 5'd0, uid, 6'd17);
        queue_item(ACT_REPLY, 1'b0, 1'b0, 5'd9, uid >> 24, 6'd16);
        // collisions at every byte boundary, then the closing reply
        uid = with_bcc(32'hA5C35A3C);
        queue_item(ACT_START, 1'b0, 1'b0, 5'd0, '0, 6'd0);
        foreach (sel_tab[i]) begin
            queue_item(ACT_REPLY, 1'b0, 1'b1, 5'(1 + 8 * i), uid, 6'd0);
            queue_item(ACT_REPLY, 1'b0, 1'b1, 5'(8 + 8 * i), uid, 6'd63);
        end
        queue_item(ACT_REPLY, 1'b0, 1'b0, 5'd0, uid >> 24, 6'd23);
        // one known byte, the card sends the remaining five
        uid = with_bcc(32'h12345678);
        queue_item(ACT_START, 1'b0, 1'b0, 5'd0, '0, 6'd0);
        queue_item(ACT_REPLY, 1'b0, 1'b1, 5'd5, uid, 6'd7);
        queue_item(ACT_REPLY, 1'b0, 1'b0, 5'd0, uid, 6'd40);
        drain();

        // random phases with different idling, select code rewritten
        // between phases while the block is empty
        for (phase = 0; phase < 4; phase++) begin
            src_idle_pct <= idle_tab[phase];
            snk_stall_pct <= stall_tab[phase];
            write_select(sel_tab[phase]);
            goal = n_queued + 145;
            while (n_queued < goal) begin
                if ($urandom_range(4) == 0)
                    queue_noise();
                else
                    queue_round();
            end
            if (phase == 0)
                hold_go <= 1'b1;
            drain();
            goal = n_queued + 145;
            while (n_queued < goal) begin
                if ($urandom_range(4) == 0)
                    queue_noise();
                else
                    queue_round();
            end
            drain();
        end
        write_select(SEL_CL1);

        if (n_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
